[rtl/odtb_pkg.sv]
// ----------------------------------------------------------------------------
// odtb_pkg
// Shared types and constants for the owned down-timer bank.
// ----------------------------------------------------------------------------
package odtb_pkg;

	// default number of timer slots
	localparam int unsigned SLOTS_DEF = 16;

	localparam int unsigned ACTION_W = 3;
	localparam int unsigned ID_W     = 32;
	localparam int unsigned SLOT_W   = 8;
	localparam int unsigned COUNT_W  = 32;

	// action codes; the remaining codes are rejected
	typedef enum logic [ACTION_W-1:0] {
		ACT_TICK   = 3'd0,
		ACT_ADD    = 3'd1,
		ACT_REMOVE = 3'd2,
		ACT_SET    = 3'd3,
		ACT_QUERY  = 3'd4
	} action_t;

	// command token walking down the cell chain, with its partial result
	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [ID_W-1:0]     owner_id;
		logic [SLOT_W-1:0]   slot;
		logic [COUNT_W-1:0]  load_value;
		logic                hit;
		logic [SLOT_W-1:0]   slot_out;
		logic [COUNT_W-1:0]  count;
		logic                running;
	} token_t;

endpackage

[rtl/odtb_req_if.sv]
// ----------------------------------------------------------------------------
// odtb_req_if
// Command channel of the timer bank: valid/ready with the command payload.
// ----------------------------------------------------------------------------
interface odtb_req_if;
	logic                            valid;
	logic                            ready;
	logic [odtb_pkg::ACTION_W-1:0]   action;
	logic [odtb_pkg::ID_W-1:0]       owner_id;
	logic [odtb_pkg::SLOT_W-1:0]     slot;
	logic [odtb_pkg::COUNT_W-1:0]    load_value;

	modport source (output valid, action, owner_id, slot, load_value, input ready);
	modport sink   (input valid, action, owner_id, slot, load_value, output ready);
endinterface

[rtl/odtb_rsp_if.sv]
// ----------------------------------------------------------------------------
// odtb_rsp_if
// Response channel of the timer bank: valid/ready with the result payload.
// ----------------------------------------------------------------------------
interface odtb_rsp_if;
	logic                            valid;
	logic                            ready;
	logic                            status;
	logic [odtb_pkg::SLOT_W-1:0]     slot_out;
	logic [odtb_pkg::COUNT_W-1:0]    count;
	logic                            running;

	modport source (output valid, status, slot_out, count, running, input ready);
	modport sink   (input valid, status, slot_out, count, running, output ready);
endinterface

[rtl/owned_down_timer_bank_top.sv]
// ----------------------------------------------------------------------------
// owned_down_timer_bank_top
// Bank of SLOTS owned down-counting timers built as a chain of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command per transfer: tick, add, remove, set or query,
//   with owner id, slot index and load value. rsp returns exactly one
//   result per command: status, claimed slot, counter and running flag.
//   A command enters cell 0 on its transfer and moves one cell per cycle while
//   the chain is not stalled; each cell applies it to its own slot (the first
//   free cell claims an add). The token passes through every cell register and
//   then lands in the output register; req.ready returns in the same cycle
//   that the result lands there. A single command is in the chain at a time:
//   req.ready is low from the transfer until the token leaves the last cell.
//   A finished result waits in the output register while rsp is stalled, and
//   the next command may already be taken and walk the chain; it then waits
//   in the last cell until the output register frees.
//   Reset clears every owner id (all slots free), all counters and all
//   handshake state.
// ----------------------------------------------------------------------------
module owned_down_timer_bank_top #(
	parameter int unsigned SLOTS = odtb_pkg::SLOTS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	odtb_req_if.sink   req,
	odtb_rsp_if.source rsp
);

	logic             vld_chain [0:SLOTS];
	odtb_pkg::token_t tok_chain [0:SLOTS];
	logic             adv;
	logic             busy_q;
	logic             accept;
	logic             pop;
	logic             rsp_vld_q;
	logic             rsp_status_q;
	logic [odtb_pkg::SLOT_W-1:0]  rsp_slot_q;
	logic [odtb_pkg::COUNT_W-1:0] rsp_count_q;
	logic                         rsp_running_q;
	logic                         last_status;
	odtb_pkg::token_t             last_tok;

	// request side
	assign req.ready = !busy_q;
	assign accept    = req.valid && !busy_q;

	// token entering the chain
	assign vld_chain[0]            = accept;
	assign tok_chain[0].action     = req.action;
	assign tok_chain[0].owner_id   = req.owner_id;
	assign tok_chain[0].slot       = req.slot;
	assign tok_chain[0].load_value = req.load_value;
	assign tok_chain[0].hit        = 1'b0;
	assign tok_chain[0].slot_out   = '0;
	assign tok_chain[0].count      = '0;
	assign tok_chain[0].running    = 1'b0;

	// chain moves unless the last token is blocked by a full output register
	assign pop = vld_chain[SLOTS] && (!rsp_vld_q || rsp.ready);
	assign adv = !(vld_chain[SLOTS] && rsp_vld_q && !rsp.ready);

	// row of slot cells
	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		odtb_cell #(
			.IDX (g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.in_vld  (vld_chain[g]),
			.in_tok  (tok_chain[g]),
			.out_vld (vld_chain[g+1]),
			.out_tok (tok_chain[g+1])
		);
	end

	// one command in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (pop) begin
			busy_q <= 1'b0;
		end
	end

	// final status from the action and whether any cell acted
	assign last_tok = tok_chain[SLOTS];
	always_comb begin
		case (last_tok.action) inside
			odtb_pkg::ACT_TICK: last_status = 1'b0;
			odtb_pkg::ACT_ADD, odtb_pkg::ACT_REMOVE,
			odtb_pkg::ACT_SET, odtb_pkg::ACT_QUERY: last_status = !last_tok.hit;
			default: last_status = 1'b1;
		endcase
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (pop) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (pop) begin
			rsp_status_q  <= last_status;
			rsp_slot_q    <= last_tok.slot_out;
			rsp_count_q   <= last_tok.count;
			rsp_running_q <= last_tok.running;
		end
	end

	assign rsp.valid    = rsp_vld_q;
	assign rsp.status   = rsp_status_q;
	assign rsp.slot_out = rsp_slot_q;
	assign rsp.count    = rsp_count_q;
	assign rsp.running  = rsp_running_q;

endmodule

[rtl/odtb_cell.sv]
// ----------------------------------------------------------------------------
// odtb_cell
// One timer slot: owner id and down counter, applies the passing command
// token to its own slot and hands the updated token to the next cell.
// ----------------------------------------------------------------------------
module odtb_cell #(
	parameter int unsigned IDX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             in_vld,
	input  odtb_pkg::token_t in_tok,
	output logic             out_vld,
	output odtb_pkg::token_t out_tok
);

	localparam logic [odtb_pkg::SLOT_W-1:0] MY_IDX = odtb_pkg::SLOT_W'(IDX);

	logic [odtb_pkg::ID_W-1:0]    owner_q;
	logic [odtb_pkg::COUNT_W-1:0] cnt_q;
	logic                         vld_q;
	odtb_pkg::token_t             tok_q;

	logic [odtb_pkg::ID_W-1:0]    owner_nxt;
	logic [odtb_pkg::COUNT_W-1:0] cnt_nxt;
	odtb_pkg::token_t             tok_nxt;
	logic                         owns;

	// slot addressed and owned by a nonzero id
	assign owns = (in_tok.slot == MY_IDX) && (in_tok.owner_id != '0)
		&& (owner_q == in_tok.owner_id);

	// apply the command to this slot
	always_comb begin
		owner_nxt = owner_q;
		cnt_nxt   = cnt_q;
		tok_nxt   = in_tok;
		case (odtb_pkg::action_t'(in_tok.action))
			odtb_pkg::ACT_TICK: begin
				if (owner_q != '0 && cnt_q != '0)
					cnt_nxt = cnt_q - odtb_pkg::COUNT_W'(1);
			end
			odtb_pkg::ACT_ADD: begin
				if (!in_tok.hit && in_tok.owner_id != '0 && owner_q == '0) begin
					owner_nxt        = in_tok.owner_id;
					cnt_nxt          = '0;
					tok_nxt.hit      = 1'b1;
					tok_nxt.slot_out = MY_IDX;
				end
			end
			odtb_pkg::ACT_REMOVE: begin
				if (owns) begin
					owner_nxt   = '0;
					tok_nxt.hit = 1'b1;
				end
			end
			odtb_pkg::ACT_SET: begin
				if (owns) begin
					cnt_nxt     = in_tok.load_value;
					tok_nxt.hit = 1'b1;
				end
			end
			odtb_pkg::ACT_QUERY: begin
				if (owns) begin
					tok_nxt.count   = cnt_q;
					tok_nxt.running = (cnt_q != '0);
					tok_nxt.hit     = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// slot state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owner_q <= '0;
			cnt_q   <= '0;
		end else if (adv && in_vld) begin
			owner_q <= owner_nxt;
			cnt_q   <= cnt_nxt;
		end
	end

	// token valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= in_vld;
		end
	end

	// token payload
	always_ff @(posedge clk) begin
		if (adv && in_vld)
			tok_q <= tok_nxt;
	end

	assign out_vld = vld_q;
	assign out_tok = tok_q;

endmodule
